// ===== rtl/mmsa_pkg.sv =====
// Shared types and constants for the masked mean and sigma accumulator.
package mmsa_pkg;

   // Default sizes; the top level takes these as parameter defaults.
   localparam int SAMPLE_BITS_DEF = 24;
   localparam int COUNT_BITS_DEF  = 16;

   // Fixed field widths on the ports.
   localparam int SAMPLE_W   = 24;
   localparam int QUALITY_W  = 8;
   localparam int MEAN_W     = 24;
   localparam int SIGMA_W    = 23;
   localparam int GCOUNT_W   = 16;
   localparam int RSP_DATA_W = 64;
   localparam int RSP_USER_W = 2;

   // Depth of the queue between the accumulate side and the finish side.
   localparam int QUEUE_DEPTH = 2;

   // Register file port.
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_QUALITY_MASK = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_USE_QUALITY  = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SIGMA_ENABLE = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_MIN_GOOD     = 8'd3;

   typedef struct packed {
      logic [QUALITY_W-1:0] quality_mask;
      logic                 use_quality;
      logic                 sigma_enable;
      logic [15:0]          min_good;
   } cfg_type;

   typedef struct packed {
      logic                status;
      logic                stats_valid;
      logic [GCOUNT_W-1:0] good_count;
      logic [SIGMA_W-1:0]  sigma;
      logic [MEAN_W-1:0]   mean;
   } result_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_DIV_MEAN,
      BK_DIV_MS,
      BK_SQUARE,
      BK_VARIANCE,
      BK_ROOT,
      BK_OUTPUT
   } back_state_type;

endpackage

// ===== rtl/mmsa_front.sv =====
// Accumulate side: classifies samples, squares them and keeps the run sums.
module mmsa_front #(
   parameter int SAMPLE_BITS = mmsa_pkg::SAMPLE_BITS_DEF,
   parameter int COUNT_BITS  = mmsa_pkg::COUNT_BITS_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  mmsa_pkg::cfg_type                             cfg,
   input  logic                                          in_valid,
   output logic                                          in_ready,
   input  logic [mmsa_pkg::SAMPLE_W-1:0]                 in_sample,
   input  logic [mmsa_pkg::QUALITY_W-1:0]                in_quality,
   input  logic                                          in_last,
   input  mmsa_pkg::queue_status_type                    q_status,
   output logic                                          push,
   output logic [3*SAMPLE_BITS+3*COUNT_BITS-2:0]         push_data
);

   localparam int SUM_BITS = SAMPLE_BITS + COUNT_BITS;
   localparam int SQ_BITS  = 2 * SAMPLE_BITS + COUNT_BITS - 1;
   localparam int SQR_BITS = 2 * SAMPLE_BITS - 1;

   localparam logic [SAMPLE_BITS-1:0] BAD_CODE  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic [COUNT_BITS-1:0]  COUNT_MAX = '1;

   logic signed [SAMPLE_BITS-1:0] sample_lo;
   logic                          good;
   logic                          advance;
   logic signed [2*SAMPLE_BITS-1:0] prod;

   // Stage A: classified sample.
   logic                          a_valid_ff, a_valid_in;
   logic signed [SAMPLE_BITS-1:0] a_sample_ff, a_sample_in;
   logic                          a_good_ff, a_good_in;
   logic                          a_last_ff, a_last_in;

   // Stage B: sample with its square.
   logic                          b_valid_ff, b_valid_in;
   logic signed [SAMPLE_BITS-1:0] b_sample_ff, b_sample_in;
   logic [SQR_BITS-1:0]           b_sq_ff, b_sq_in;
   logic                          b_good_ff, b_good_in;
   logic                          b_last_ff, b_last_in;

   // Run accumulators.
   logic signed [SUM_BITS-1:0]    sum_ff, sum_in, sum_next;
   logic [SQ_BITS-1:0]            sumsq_ff, sumsq_in, sumsq_next;
   logic [COUNT_BITS-1:0]         count_ff, count_in, count_next;
   logic                          take;

   assign sample_lo = $signed(in_sample[SAMPLE_BITS-1:0]);
   assign good      = cfg.use_quality ? ((in_quality & cfg.quality_mask) == '0)
                                      : (sample_lo != BAD_CODE);

   // Hold the whole pipe while a finished run waits for queue space.
   assign advance  = !(b_valid_ff && b_last_ff && q_status.full);
   assign in_ready = advance;

   assign prod = a_sample_ff * a_sample_ff;

   assign take       = b_valid_ff && b_good_ff && (count_ff != COUNT_MAX);
   assign sum_next   = take ? sum_ff + SUM_BITS'(b_sample_ff) : sum_ff;
   assign sumsq_next = take ? sumsq_ff + SQ_BITS'(b_sq_ff) : sumsq_ff;
   assign count_next = take ? count_ff + 1'b1 : count_ff;
   assign push_data  = {count_next, sumsq_next, sum_next};

   always_comb begin
      a_valid_in  = a_valid_ff;
      a_sample_in = a_sample_ff;
      a_good_in   = a_good_ff;
      a_last_in   = a_last_ff;
      b_valid_in  = b_valid_ff;
      b_sample_in = b_sample_ff;
      b_sq_in     = b_sq_ff;
      b_good_in   = b_good_ff;
      b_last_in   = b_last_ff;
      sum_in      = sum_ff;
      sumsq_in    = sumsq_ff;
      count_in    = count_ff;
      push        = 1'b0;
      if (advance) begin
         a_valid_in  = in_valid;
         a_sample_in = sample_lo;
         a_good_in   = good;
         a_last_in   = in_last;
         b_valid_in  = a_valid_ff;
         b_sample_in = a_sample_ff;
         b_sq_in     = prod[SQR_BITS-1:0];
         b_good_in   = a_good_ff;
         b_last_in   = a_last_ff;
         if (b_valid_ff && b_last_ff) begin
            // Hand the finished run to the queue and start a new one.
            push     = 1'b1;
            sum_in   = '0;
            sumsq_in = '0;
            count_in = '0;
         end else begin
            sum_in   = sum_next;
            sumsq_in = sumsq_next;
            count_in = count_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         sum_ff     <= '0;
         sumsq_ff   <= '0;
         count_ff   <= '0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         sum_ff     <= sum_in;
         sumsq_ff   <= sumsq_in;
         count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      a_sample_ff <= a_sample_in;
      a_good_ff   <= a_good_in;
      a_last_ff   <= a_last_in;
      b_sample_ff <= b_sample_in;
      b_sq_ff     <= b_sq_in;
      b_good_ff   <= b_good_in;
      b_last_ff   <= b_last_in;
   end

endmodule

// ===== rtl/mmsa_queue.sv =====
// Small FIFO of finished run totals between the accumulate and finish sides.
module mmsa_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = mmsa_pkg::QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output mmsa_pkg::queue_status_type status
);

   localparam int PTR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0]  PTR_LAST = PTR_BITS'(DEPTH - 1);
   localparam logic [FILL_BITS-1:0] FILL_MAX = FILL_BITS'(DEPTH);

   logic [WIDTH-1:0]     entries_ff [DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_BITS-1:0] fill_ff, fill_in;

   assign status.full  = (fill_ff == FILL_MAX);
   assign status.empty = (fill_ff == '0);
   assign pop_data     = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/mmsa_back.sv =====
// Finish side: divides the run totals, takes the square root and holds the result.
module mmsa_back #(
   parameter int SAMPLE_BITS = mmsa_pkg::SAMPLE_BITS_DEF,
   parameter int COUNT_BITS  = mmsa_pkg::COUNT_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mmsa_pkg::cfg_type                     cfg,
   input  mmsa_pkg::queue_status_type            q_status,
   output logic                                  pop,
   input  logic [3*SAMPLE_BITS+3*COUNT_BITS-2:0] pop_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output mmsa_pkg::result_type                  result
);

   localparam int SUM_BITS   = SAMPLE_BITS + COUNT_BITS;
   localparam int SQ_BITS    = 2 * SAMPLE_BITS + COUNT_BITS - 1;
   localparam int ENTRY_BITS = SUM_BITS + SQ_BITS + COUNT_BITS;
   localparam int DIV_BITS   = SQ_BITS;
   localparam int MS_BITS    = 2 * SAMPLE_BITS;
   localparam int STEP_BITS  = $clog2(DIV_BITS);
   localparam logic [STEP_BITS-1:0] LAST_DIV  = STEP_BITS'(DIV_BITS - 1);
   localparam logic [STEP_BITS-1:0] LAST_ROOT = STEP_BITS'(SAMPLE_BITS - 1);

   // Queue entry fields.
   logic [COUNT_BITS-1:0]      pop_cnt;
   logic [SQ_BITS-1:0]         pop_sq;
   logic signed [SUM_BITS-1:0] pop_sum;
   logic [SUM_BITS-1:0]        sum_mag;

   mmsa_pkg::back_state_type state_ff, state_in;
   logic [STEP_BITS-1:0]      step_ff, step_in;
   logic [COUNT_BITS-1:0]     cnt_ff, cnt_in;
   logic                      neg_ff, neg_in;
   logic [SQ_BITS-1:0]        sumsq_ff, sumsq_in;
   logic [DIV_BITS-1:0]       dvd_ff, dvd_in;
   logic [COUNT_BITS-1:0]     rem_ff, rem_in;
   logic signed [SAMPLE_BITS-1:0] mean_ff, mean_in;
   logic [MS_BITS-1:0]        ms_ff, ms_in;
   logic [MS_BITS-1:0]        msq_ff, msq_in;
   logic [MS_BITS-1:0]        rad_ff, rad_in;
   logic [SAMPLE_BITS-1:0]    root_ff, root_in;
   logic [SAMPLE_BITS+1:0]    rrem_ff, rrem_in;
   logic [mmsa_pkg::SIGMA_W-1:0] sigma_ff, sigma_in;
   logic                      out_valid_ff, out_valid_in;
   mmsa_pkg::result_type      out_ff, out_in;

   // Restoring divider step, one quotient bit a cycle.
   logic [COUNT_BITS:0]       div_shift;
   logic [COUNT_BITS:0]       div_diff;
   logic                      div_ge;
   logic [COUNT_BITS-1:0]     div_rem;
   logic [DIV_BITS-1:0]       div_quo;
   logic [SAMPLE_BITS-1:0]    quo_lo;

   // Square root step, one root bit a cycle.
   logic [SAMPLE_BITS+3:0]    sq_shift;
   logic [SAMPLE_BITS+3:0]    sq_trial;
   logic [SAMPLE_BITS+3:0]    sq_diff;
   logic                      sq_ge;
   logic [SAMPLE_BITS-1:0]    root_step;
   logic [mmsa_pkg::MEAN_W-1:0] root_wide;

   logic signed [MS_BITS-1:0] msq_prod;

   assign pop_cnt = pop_data[ENTRY_BITS-1 -: COUNT_BITS];
   assign pop_sq  = pop_data[SUM_BITS +: SQ_BITS];
   assign pop_sum = $signed(pop_data[SUM_BITS-1:0]);
   assign sum_mag = pop_sum[SUM_BITS-1] ? $unsigned(-pop_sum) : $unsigned(pop_sum);

   assign div_shift = {rem_ff, dvd_ff[DIV_BITS-1]};
   assign div_diff  = div_shift - {1'b0, cnt_ff};
   assign div_ge    = (div_shift >= {1'b0, cnt_ff});
   assign div_rem   = div_ge ? div_diff[COUNT_BITS-1:0] : div_shift[COUNT_BITS-1:0];
   assign div_quo   = {dvd_ff[DIV_BITS-2:0], div_ge};
   assign quo_lo    = div_quo[SAMPLE_BITS-1:0];

   assign sq_shift  = {rrem_ff, rad_ff[MS_BITS-1 -: 2]};
   assign sq_trial  = {2'b00, root_ff, 2'b01};
   assign sq_diff   = sq_shift - sq_trial;
   assign sq_ge     = (sq_shift >= sq_trial);
   assign root_step = {root_ff[SAMPLE_BITS-2:0], sq_ge};
   assign root_wide = mmsa_pkg::MEAN_W'(root_step);

   assign msq_prod = mean_ff * mean_ff;

   assign rsp_valid = out_valid_ff;
   assign result    = out_ff;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      sumsq_in     = sumsq_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      mean_in      = mean_ff;
      ms_in        = ms_ff;
      msq_in       = msq_ff;
      rad_in       = rad_ff;
      root_in      = root_ff;
      rrem_in      = rrem_ff;
      sigma_in     = sigma_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_in       = out_ff;
      pop          = 1'b0;
      case (state_ff)
         mmsa_pkg::BK_IDLE: begin
            if (!q_status.empty) begin
               pop      = 1'b1;
               cnt_in   = pop_cnt;
               neg_in   = pop_sum[SUM_BITS-1];
               sumsq_in = pop_sq;
               dvd_in   = DIV_BITS'(sum_mag);
               rem_in   = '0;
               step_in  = '0;
               mean_in  = '0;
               sigma_in = '0;
               // An empty run skips straight to the result.
               state_in = (pop_cnt == '0) ? mmsa_pkg::BK_OUTPUT : mmsa_pkg::BK_DIV_MEAN;
            end
         end
         mmsa_pkg::BK_DIV_MEAN: begin
            dvd_in  = div_quo;
            rem_in  = div_rem;
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_DIV) begin
               mean_in  = neg_ff ? $signed(-quo_lo) : $signed(quo_lo);
               dvd_in   = sumsq_ff;
               rem_in   = '0;
               step_in  = '0;
               state_in = cfg.sigma_enable ? mmsa_pkg::BK_DIV_MS : mmsa_pkg::BK_OUTPUT;
            end
         end
         mmsa_pkg::BK_DIV_MS: begin
            dvd_in  = div_quo;
            rem_in  = div_rem;
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_DIV) begin
               ms_in    = div_quo[MS_BITS-1:0];
               state_in = mmsa_pkg::BK_SQUARE;
            end
         end
         mmsa_pkg::BK_SQUARE: begin
            msq_in   = $unsigned(msq_prod);
            state_in = mmsa_pkg::BK_VARIANCE;
         end
         mmsa_pkg::BK_VARIANCE: begin
            rad_in   = (ms_ff > msq_ff) ? ms_ff - msq_ff : '0;
            root_in  = '0;
            rrem_in  = '0;
            step_in  = '0;
            state_in = mmsa_pkg::BK_ROOT;
         end
         mmsa_pkg::BK_ROOT: begin
            rad_in  = {rad_ff[MS_BITS-3:0], 2'b00};
            root_in = root_step;
            rrem_in = sq_ge ? sq_diff[SAMPLE_BITS+1:0] : sq_shift[SAMPLE_BITS+1:0];
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_ROOT) begin
               sigma_in = root_wide[mmsa_pkg::MEAN_W-1] ? '1
                                                      : root_wide[mmsa_pkg::SIGMA_W-1:0];
               state_in = mmsa_pkg::BK_OUTPUT;
            end
         end
         mmsa_pkg::BK_OUTPUT: begin
            if (!out_valid_ff || rsp_ready) begin
               out_valid_in       = 1'b1;
               out_in.mean        = mmsa_pkg::MEAN_W'(mean_ff);
               out_in.sigma       = sigma_ff;
               out_in.good_count  = mmsa_pkg::GCOUNT_W'(cnt_ff);
               out_in.stats_valid = (cnt_ff != '0);
               out_in.status      = (16'(cnt_ff) < cfg.min_good);
               state_in           = mmsa_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = mmsa_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mmsa_pkg::BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      cnt_ff   <= cnt_in;
      neg_ff   <= neg_in;
      sumsq_ff <= sumsq_in;
      dvd_ff   <= dvd_in;
      rem_ff   <= rem_in;
      mean_ff  <= mean_in;
      ms_ff    <= ms_in;
      msq_ff   <= msq_in;
      rad_ff   <= rad_in;
      root_ff  <= root_in;
      rrem_ff  <= rrem_in;
      sigma_ff <= sigma_in;
      out_ff   <= out_in;
   end

endmodule

// ===== rtl/masked_mean_sigma_accumulator.sv =====
// Top level of the masked mean and sigma accumulator.
//
// Usage: samples arrive on the req_ stream, one per cycle while req_tready is
// high; req_tlast marks the final sample of a run. Each run yields one item on
// the rsp_ stream with the mean, sigma and good-sample count of the samples that
// passed the mask. Registers are written through the csr_ channel, which is
// always ready; write them only while no run is in flight.
// Throughput: the accumulate side takes one sample every cycle while req_tready
// is high. The finish side works through a run with its bit-serial divider,
// run twice, and its bit-serial square root; with sigma disabled it stops
// after the first divide, and an empty run skips straight to the result. A
// two-entry queue of run totals sits between the sides, so short runs throttle
// req_tready only once it fills.
// A run's last sample passes stage A and stage B before its totals enter the
// queue; the finish side then computes the result into the output register.
// Reset: clears the registers to their defaults, the sums and all valid state.
// Stall: a result is held in the output register while rsp_tready is low; the
// finish side and then the queue back up behind it, and req_tready drops only
// when a run end cannot enter the full queue.
module masked_mean_sigma_accumulator #(
   parameter int SAMPLE_BITS = mmsa_pkg::SAMPLE_BITS_DEF,
   parameter int COUNT_BITS  = mmsa_pkg::COUNT_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // Input stream.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [mmsa_pkg::SAMPLE_W-1:0]       req_tdata,  // [23:0] sample
   input  logic [mmsa_pkg::QUALITY_W-1:0]      req_tuser,  // [7:0] quality
   input  logic                                req_tlast,
   // Result stream.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [mmsa_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // [23:0] mean, [46:24] sigma,
                                                           // [62:47] good_count, [63] zero
   output logic [mmsa_pkg::RSP_USER_W-1:0]     rsp_tuser,  // [0] stats_valid, [1] status
   // Register writes.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mmsa_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mmsa_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int ENTRY_BITS = 3 * SAMPLE_BITS + 3 * COUNT_BITS - 1;

   mmsa_pkg::cfg_type          cfg_ff, cfg_in;
   mmsa_pkg::queue_status_type q_status;
   mmsa_pkg::result_type       result;
   logic                       push;
   logic                       pop;
   logic [ENTRY_BITS-1:0]      push_data;
   logic [ENTRY_BITS-1:0]      pop_data;

   // Register file: every write lands at once; unknown indexes drop.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            mmsa_pkg::REG_QUALITY_MASK: cfg_in.quality_mask = csr_data[mmsa_pkg::QUALITY_W-1:0];
            mmsa_pkg::REG_USE_QUALITY:  cfg_in.use_quality  = csr_data[0];
            mmsa_pkg::REG_SIGMA_ENABLE: cfg_in.sigma_enable = csr_data[0];
            mmsa_pkg::REG_MIN_GOOD:     cfg_in.min_good     = csr_data[15:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.quality_mask <= '0;
         cfg_ff.use_quality  <= 1'b0;
         cfg_ff.sigma_enable <= 1'b1;
         cfg_ff.min_good     <= 16'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Accumulate side: classify, square and sum each sample.
   mmsa_front #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_sample  (req_tdata),
      .in_quality (req_tuser),
      .in_last    (req_tlast),
      .q_status   (q_status),
      .push       (push),
      .push_data  (push_data)
   );

   // Run totals waiting for the finish side.
   mmsa_queue #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (mmsa_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   // Finish side: mean, variance, sigma and the output register.
   mmsa_back #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_status  (q_status),
      .pop       (pop),
      .pop_data  (pop_data),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .result    (result)
   );

   assign rsp_tdata = {1'b0, result.good_count, result.sigma, result.mean};
   assign rsp_tuser = {result.status, result.stats_valid};

endmodule

// ===== rtl/mmsa_checker.sv =====
// Port-level checks for the masked mean and sigma accumulator, with its bind.
module mmsa_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [mmsa_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic [mmsa_pkg::RSP_USER_W-1:0]   rsp_tuser
);

   // Reset empties the output register.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // stats_valid tracks a nonzero good count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[0] == (rsp_tdata[62:47] != 16'd0)))
      else $error("stats_valid disagrees with good_count");

   // A run without good samples reports zero mean and sigma.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> (rsp_tdata[46:0] == 47'd0))
      else $error("empty run has nonzero mean or sigma");

endmodule

bind masked_mean_sigma_accumulator mmsa_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
